@@ src/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define NNGS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that holds through reset as well.
`define NNGS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/nngs_pkg.sv @@
`default_nettype none

package nngs_pkg;

  localparam int unsigned MAX_SIDE_DEF    = 256;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned STORE_DEPTH = 65536;
  localparam int unsigned STORE_AW    = 16;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned VALUE_W = 16;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic {
    BND_ZERO      = 1'b0,
    BND_REPLICATE = 1'b1
  } bnd_mode_e;

  typedef enum logic [2:0] {
    REG_BOUNDARY_MODE = 3'd0,
    REG_ORIGIN_X      = 3'd1,
    REG_ORIGIN_Y      = 3'd2,
    REG_INV_SPACING_X = 3'd3,
    REG_INV_SPACING_Y = 3'd4,
    REG_SIZE_X        = 3'd5,
    REG_SIZE_Y        = 3'd6
  } reg_idx_e;

  // Per-axis mapping settings handed to an axis unit.
  typedef struct packed {
    logic [COORD_W-1:0] origin;
    logic [COORD_W-1:0] inv;
  } axis_cfg_t;

endpackage

`default_nettype wire

@@ src/nngs_axis.sv @@
`default_nettype none

// Maps one coordinate to a cell index over four stages:
// difference, magnitude, scale, round and bound.
module nngs_axis #(
  parameter int unsigned MAX_SIDE = nngs_pkg::MAX_SIDE_DEF,
  localparam int unsigned NW = $clog2(MAX_SIDE + 1),
  localparam int unsigned IW = $clog2(MAX_SIDE)
) (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire nngs_pkg::axis_cfg_t            cfg_i,
  input  wire logic [NW-1:0]                  n_i,
  input  wire logic [nngs_pkg::COORD_W-1:0]   coord_i,
  output logic      [IW-1:0]                  idx_o,
  output logic                                oob_o
);

  localparam int unsigned CW = nngs_pkg::COORD_W;

  logic [CW:0]     diff_q, diff_d;
  logic [CW-1:0]   mag_q, mag_d;
  logic            pos2_q, pos2_d;
  logic [CW-1:0]   ipart_q, ipart_d;
  logic            pos3_q;
  logic [2*CW-1:0] prod;
  logic [NW-1:0]   n_m1;
  logic            big;
  logic [IW-1:0]   idx_q, idx_d;
  logic            oob_q, oob_d;
  logic [CW:0]     diff_neg;

  assign diff_d   = {coord_i[CW-1], coord_i} - {cfg_i.origin[CW-1], cfg_i.origin};
  assign diff_neg = -diff_q;

  // Positive distance with a non-zero scale floors; everything else gives ceil - 1.
  assign pos2_d = !diff_q[CW] && (diff_q != '0) && (cfg_i.inv != '0);
  assign mag_d  = diff_q[CW] ? diff_neg[CW-1:0] : diff_q[CW-1:0];

  assign prod    = mag_q * cfg_i.inv;
  assign ipart_d = prod[2*CW-1:CW];

  assign n_m1 = n_i - NW'(1);
  assign big  = ipart_q > CW'(n_m1);

  always_comb begin
    if (!pos3_q) begin
      idx_d = '0;
      oob_d = 1'b1;
    end else if (big) begin
      idx_d = n_m1[IW-1:0];
      oob_d = 1'b1;
    end else begin
      idx_d = ipart_q[IW-1:0];
      oob_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q  <= diff_d;
      mag_q   <= mag_d;
      pos2_q  <= pos2_d;
      ipart_q <= ipart_d;
      pos3_q  <= pos2_q;
      idx_q   <= idx_d;
      oob_q   <= oob_d;
    end
  end

  assign idx_o = idx_q;
  assign oob_o = oob_q;

endmodule

`default_nettype wire

@@ src/nearest_neighbor_grid_sampler_core.sv @@
`default_nettype none

// Nearest-neighbour sampler over a cell-centred 2D grid held in a 65536-entry
// sample store. Each input word is either a sample write (tuser 0) or a point
// query (tuser 1); a query returns one output word, a write returns none.
// One word is accepted per cycle unless an output word is stalled; four
// stages map the coordinates to cell indices (one 32x32 multiply per axis),
// one forms the store address, one reads or writes the single-port store,
// and one holds the output word. Writes and queries pass the store in
// arrival order, so a query sees every earlier write. The whole pipeline
// halts while an output word waits to be taken. The store is not cleared:
// query only entries that have been written. Program the registers only
// while no words are in flight.
module nearest_neighbor_grid_sampler_core #(
  parameter int unsigned MAX_SIDE    = nngs_pkg::MAX_SIDE_DEF,
  parameter int unsigned SAMPLE_BITS = nngs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // coord_x [31:0], coord_y [63:32], sample_index [79:64], sample_value [95:80]
  input  wire logic [95:0] s_axis_tdata,
  // cmd [0]
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // result_value [15:0]
  output logic [15:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned NW  = $clog2(MAX_SIDE + 1);
  localparam int unsigned IW  = $clog2(MAX_SIDE);
  localparam int unsigned SW  = nngs_pkg::SIZE_W;
  localparam int unsigned CMW = (NW > SW) ? NW : SW;
  localparam int unsigned AW  = nngs_pkg::STORE_AW;
  localparam int unsigned PW  = NW + IW + 1;
  localparam int unsigned XW  = (PW > AW) ? PW : AW;
  localparam int unsigned VW  = nngs_pkg::VALUE_W;
  localparam int unsigned EW  = 48;
  localparam int unsigned DEPTH = 4;

  // Configuration registers
  nngs_pkg::bnd_mode_e mode_q;
  logic [31:0]         origin_x_q, origin_y_q, inv_x_q, inv_y_q;
  logic [SW-1:0]       size_x_q, size_y_q;
  logic                cfg_wr;
  nngs_pkg::reg_idx_e  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = nngs_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= nngs_pkg::BND_ZERO;
      origin_x_q <= '0;
      origin_y_q <= '0;
      inv_x_q    <= 32'd65536;
      inv_y_q    <= 32'd65536;
      size_x_q   <= SW'(256);
      size_y_q   <= SW'(256);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        nngs_pkg::REG_BOUNDARY_MODE: mode_q     <= nngs_pkg::bnd_mode_e'(pwdata[0]);
        nngs_pkg::REG_ORIGIN_X:      origin_x_q <= pwdata;
        nngs_pkg::REG_ORIGIN_Y:      origin_y_q <= pwdata;
        nngs_pkg::REG_INV_SPACING_X: inv_x_q    <= pwdata;
        nngs_pkg::REG_INV_SPACING_Y: inv_y_q    <= pwdata;
        nngs_pkg::REG_SIZE_X:        size_x_q   <= pwdata[SW-1:0];
        nngs_pkg::REG_SIZE_Y:        size_y_q   <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      nngs_pkg::REG_BOUNDARY_MODE: prdata = {31'b0, mode_q};
      nngs_pkg::REG_ORIGIN_X:      prdata = origin_x_q;
      nngs_pkg::REG_ORIGIN_Y:      prdata = origin_y_q;
      nngs_pkg::REG_INV_SPACING_X: prdata = inv_x_q;
      nngs_pkg::REG_INV_SPACING_Y: prdata = inv_y_q;
      nngs_pkg::REG_SIZE_X:        prdata = 32'(size_x_q);
      nngs_pkg::REG_SIZE_Y:        prdata = 32'(size_y_q);
      default:                     prdata = '0;
    endcase
  end

  // Saturate a size register into 1..MAX_SIDE.
  function automatic logic [NW-1:0] eff_size(input logic [SW-1:0] s);
    logic [CMW-1:0] se;
    se = CMW'(s);
    if (se == '0) begin
      eff_size = NW'(1);
    end else if (se > CMW'(MAX_SIDE)) begin
      eff_size = NW'(MAX_SIDE);
    end else begin
      eff_size = se[NW-1:0];
    end
  endfunction

  logic [NW-1:0] nx, ny;
  assign nx = eff_size(size_x_q);
  assign ny = eff_size(size_y_q);

  // Pipeline advance: everything moves unless the output word is stalled.
  logic en;
  logic out_valid_q;
  logic [VW-1:0] out_data_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Index stages
  nngs_pkg::axis_cfg_t cfg_x, cfg_y;
  logic [IW-1:0] xi, yi;
  logic          oob_x, oob_y;

  assign cfg_x = '{origin: origin_x_q, inv: inv_x_q};
  assign cfg_y = '{origin: origin_y_q, inv: inv_y_q};

  nngs_axis #(.MAX_SIDE(MAX_SIDE)) u_axis_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .cfg_i  (cfg_x),
    .n_i    (nx),
    .coord_i(s_axis_tdata[31:0]),
    .idx_o  (xi),
    .oob_o  (oob_x)
  );

  nngs_axis #(.MAX_SIDE(MAX_SIDE)) u_axis_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .cfg_i  (cfg_y),
    .n_i    (ny),
    .coord_i(s_axis_tdata[63:32]),
    .idx_o  (yi),
    .oob_o  (oob_y)
  );

  // Side band alongside the index stages
  logic [DEPTH-1:0] vld_q;
  logic [DEPTH-1:0] cmd_q;
  logic [AW-1:0]    waddr_q [DEPTH];
  logic [VW-1:0]    wdata_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_q      <= {cmd_q[DEPTH-2:0], s_axis_tuser};
      waddr_q[0] <= s_axis_tdata[79:64];
      wdata_q[0] <= s_axis_tdata[95:80];
      for (int i = 1; i < DEPTH; i++) begin
        waddr_q[i] <= waddr_q[i-1];
        wdata_q[i] <= wdata_q[i-1];
      end
    end
  end

  // Address stage
  logic                   v5_q, cmd5_q, oob5_q;
  logic [AW-1:0]          addr5_q, addr5_d;
  logic [SAMPLE_BITS-1:0] wdata5_q, wdata5_d;
  logic [XW-1:0]          lin;
  logic signed [EW-1:0]   wext;
  logic                   is_query4;

  assign is_query4 = cmd_q[DEPTH-1] == nngs_pkg::CMD_QUERY;
  assign lin       = XW'(xi) + XW'(nx) * XW'(yi);
  assign addr5_d   = is_query4 ? lin[AW-1:0] : waddr_q[DEPTH-1];
  assign wext      = EW'(signed'(wdata_q[DEPTH-1]));
  assign wdata5_d  = wext[SAMPLE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= vld_q[DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd5_q   <= cmd_q[DEPTH-1];
      addr5_q  <= addr5_d;
      wdata5_q <= wdata5_d;
      oob5_q   <= (mode_q == nngs_pkg::BND_ZERO) && (oob_x || oob_y);
    end
  end

  // Sample store: one access per cycle, read data held while stalled
  logic [SAMPLE_BITS-1:0] store [nngs_pkg::STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic                   v6_q, cmd6_q, oob6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (v5_q && (cmd5_q == nngs_pkg::CMD_WRITE)) begin
        store[addr5_q] <= wdata5_q;
      end
      rd_q <= store[addr5_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd6_q <= cmd5_q;
      oob6_q <= oob5_q;
    end
  end

  // Output word
  logic signed [EW-1:0] rext;
  assign rext = EW'(signed'(rd_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v6_q && (cmd6_q == nngs_pkg::CMD_QUERY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= oob6_q ? '0 : rext[VW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

@@ src/nngs_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module nngs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        pready
);

  // A stalled result word stays offered and unchanged.
  `NNGS_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result word dropped while stalled")
  `NNGS_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result word changed while stalled")

  // Input back-pressure only ever comes from a stalled result word.
  `NNGS_ASSERT(a_ready_cause, clk_i, rst_ni, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

  // The register port never inserts wait states.
  `NNGS_ASSERT_ALWAYS(a_pready, clk_i, pready, "register port not ready")

endmodule

bind nearest_neighbor_grid_sampler_core nngs_checker u_nngs_checker (.*);

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_PAD   = 20;

  // Scoreboard: own copy of the registers and the sample store, and the queue
  // of sample values that queries accepted so far should return.
  class grid_sample_board;
    nngs_pkg::bnd_mode_e mode;
    int          org_x, org_y;
    bit [31:0]   inv_x, inv_y;
    bit [8:0]    side_x, side_y;
    logic [15:0] image [0:65535];
    logic [15:0] lookup_q [$];
    int          errors;

    function new();
      mode   = nngs_pkg::BND_ZERO;
      org_x  = 0;
      org_y  = 0;
      inv_x  = 32'h0001_0000;
      inv_y  = 32'h0001_0000;
      side_x = 9'd256;
      side_y = 9'd256;
      errors = 0;
    endfunction

    function void set_reg(nngs_pkg::reg_idx_e r, bit [31:0] v);
      case (r)
        nngs_pkg::REG_BOUNDARY_MODE: mode = nngs_pkg::bnd_mode_e'(v[0]);
        nngs_pkg::REG_ORIGIN_X:      org_x = int'(v);
        nngs_pkg::REG_ORIGIN_Y:      org_y = int'(v);
        nngs_pkg::REG_INV_SPACING_X: inv_x = v;
        nngs_pkg::REG_INV_SPACING_Y: inv_y = v;
        nngs_pkg::REG_SIZE_X:        side_x = v[8:0];
        nngs_pkg::REG_SIZE_Y:        side_y = v[8:0];
        default: ;
      endcase
    endfunction

    static function longint eff_side(bit [8:0] s);
      if (s == 0) return 1;
      if (s > nngs_pkg::MAX_SIDE_DEF) return nngs_pkg::MAX_SIDE_DEF;
      return longint'(s);
    endfunction

    // Round (s - 0.5) half away from zero, s = (coord - origin) * inv exactly.
    static function longint cell_index(int coord, int org, bit [31:0] inv);
      longint    diff;
      bit [63:0] mag;
      bit [63:0] prod;
      longint    whole;
      diff  = longint'(coord) - longint'(org);
      mag   = (diff < 0) ? -diff : diff;
      prod  = mag * {32'b0, inv};
      whole = longint'({32'b0, prod[63:32]});
      return (diff > 0 && inv != 0) ? whole : -whole - 1;
    endfunction

    static function longint clamp_to(longint v, longint n);
      if (v < 0) return 0;
      if (v > n - 1) return n - 1;
      return v;
    endfunction

    // Returns 1 when the query reads the store, with the address it reads.
    function bit lookup_addr(int x, int y, output bit [15:0] addr);
      longint nx, ny, xi, yi;
      nx = eff_side(side_x);
      ny = eff_side(side_y);
      xi = cell_index(x, org_x, inv_x);
      yi = cell_index(y, org_y, inv_y);
      addr = '0;
      if (mode == nngs_pkg::BND_REPLICATE) begin
        xi = clamp_to(xi, nx);
        yi = clamp_to(yi, ny);
      end else if (xi < 0 || yi < 0 || xi > nx - 1 || yi > ny - 1) begin
        return 1'b0;
      end
      addr = 16'(xi + nx * yi);
      return 1'b1;
    endfunction

    function void note_word(bit cmd, bit [95:0] d);
      bit [15:0] addr;
      if (nngs_pkg::cmd_e'(cmd) == nngs_pkg::CMD_WRITE) begin
        image[d[79:64]] = d[95:80];
      end else if (lookup_addr(int'(d[31:0]), int'(d[63:32]), addr)) begin
        lookup_q.push_back(image[addr]);
      end else begin
        lookup_q.push_back(16'h0000);
      end
    endfunction

    function void check_result(logic [15:0] got);
      logic [15:0] exp_v;
      if (lookup_q.size() == 0) begin
        $error("result_value: no query waiting, actual %0d", $signed(got));
        errors++;
        return;
      end
      exp_v = lookup_q.pop_front();
      if (got !== exp_v) begin
        $error("result_value: expected %0d, actual %0d", $signed(exp_v), $signed(got));
        errors++;
      end
    endfunction

    function int pending();
      return lookup_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic [95:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  grid_sample_board sb = new();
  bit src_gaps  = 1'b1;
  bit sink_gaps = 1'b1;
  bit issued_q [0:65535];
  int quiet_cycles = 0;

  nearest_neighbor_grid_sampler_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: stall a random number of cycles before taking each word.
  initial begin
    int stall;
    forever begin
      stall = sink_gaps ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_word(nngs_pkg::cmd_e c, int x, int y, bit [15:0] idx, bit [15:0] val);
    int gap;
    gap = src_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {val, idx, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_sample(bit [15:0] idx, bit [15:0] val);
    send_word(nngs_pkg::CMD_WRITE, $urandom, $urandom, idx, val);
    issued_q[idx] = 1'b1;
  endtask

  // Fill the entry a query is going to read first if it was never written.
  task automatic query_point(int x, int y);
    bit [15:0] addr;
    if (sb.lookup_addr(x, y, addr) && !issued_q[addr]) write_sample(addr, 16'($urandom));
    send_word(nngs_pkg::CMD_QUERY, x, y, 16'($urandom), 16'($urandom));
  endtask

  // Hold the input, wait for every result, then let in-flight writes retire.
  task automatic settle(int tail);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (tail) @(posedge clk_i);
  endtask

  // Setup and access phases, then idle before the next transfer.
  task automatic reg_write(nngs_pkg::reg_idx_e r, bit [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(r, v);
    @(posedge clk_i);
  endtask

  task automatic configure(nngs_pkg::bnd_mode_e m, bit [31:0] ox, bit [31:0] oy,
                           bit [31:0] ix, bit [31:0] iy, bit [8:0] sx, bit [8:0] sy);
    reg_write(nngs_pkg::REG_BOUNDARY_MODE, {31'b0, m});
    reg_write(nngs_pkg::REG_ORIGIN_X, ox);
    reg_write(nngs_pkg::REG_ORIGIN_Y, oy);
    reg_write(nngs_pkg::REG_INV_SPACING_X, ix);
    reg_write(nngs_pkg::REG_INV_SPACING_Y, iy);
    reg_write(nngs_pkg::REG_SIZE_X, {23'b0, sx});
    reg_write(nngs_pkg::REG_SIZE_Y, {23'b0, sy});
  endtask

  // Coordinate a few cells around the grid, now and then on a rounding tie.
  function automatic int pick_coord(int org, bit [31:0] inv, bit [8:0] sz);
    longint n, cell_w, lim, delta;
    n      = grid_sample_board::eff_side(sz);
    cell_w = (inv == 0) ? 65536 : longint'(64'h1_0000_0000 / inv);
    lim    = (n + 4) * cell_w;
    if ($urandom_range(0, 3) == 0) begin
      delta = longint'($urandom_range(0, 32'(n + 1))) * cell_w - cell_w;
      if ($urandom_range(0, 1)) delta += cell_w / 2;
    end else if (lim > 64'hFFFF_FFFF) begin
      delta = longint'(int'($urandom));
    end else begin
      delta = longint'($urandom_range(0, 32'(lim))) - 2 * cell_w;
    end
    return int'(longint'(org) + delta);
  endfunction

  task automatic random_items(int count);
    int     pick;
    longint span;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      span = grid_sample_board::eff_side(sb.side_x) * grid_sample_board::eff_side(sb.side_y);
      if (pick < 25) begin
        write_sample(pick < 12 ? 16'($urandom_range(0, 32'(span - 1))) : 16'($urandom),
                     16'($urandom));
      end else if (pick < 37) begin
        query_point($urandom, $urandom);
      end else begin
        query_point(pick_coord(sb.org_x, sb.inv_x, sb.side_x),
                    pick_coord(sb.org_y, sb.inv_y, sb.side_y));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero padding, unit cells from the origin, full 256 x 256 grid.
    write_sample(16'h0000, 16'h7FFF);
    write_sample(16'hFFFF, 16'h8000);
    write_sample(16'h5A5A, 16'hA5A5);
    query_point(32'h0000_8000, 32'h0000_8000);
    query_point(32'h00FF_8000, 32'h00FF_8000);
    query_point(32'h0001_0000, 32'h0000_8000);
    query_point(32'h0000_8000, 32'h0001_8000);
    query_point(32'h0000_0000, 32'h0000_0000);
    query_point(32'h0100_8000, 32'h0000_8000);
    query_point(32'h0100_0000, 32'h0001_0000);
    query_point(32'hFFFF_FFFF, 32'h0000_8000);
    query_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    query_point(32'h8000_0000, 32'h8000_0000);
    query_point(32'h005A_8000, 32'h005A_8000);
    random_items(50);

    settle(DRAIN_PAD);
    configure(nngs_pkg::BND_REPLICATE, 32'hFFFA_C000, 32'h0003_0000, 32'h0002_0000,
              32'h0000_8000, 9'd16, 9'd8);
    random_items(35);
    settle(0);
    random_items(35);

    // Back-to-back words, extreme origins and spacings, one row.
    settle(DRAIN_PAD);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    configure(nngs_pkg::BND_ZERO, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
              32'h0000_0001, 9'd256, 9'd1);
    random_items(80);

    // Sizes outside the legal range saturate; zero spacing pins both indices.
    settle(DRAIN_PAD);
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    configure(nngs_pkg::BND_REPLICATE, $urandom, $urandom, 32'h0, 32'h0, 9'd0, 9'd511);
    random_items(50);

    // One-dimensional use with zero padding.
    settle(DRAIN_PAD);
    configure(nngs_pkg::BND_ZERO, $urandom, 32'h0, 32'h0001_8000, 32'h0001_0000,
              9'd100, 9'd1);
    query_point(sb.org_x + 32'h0000_C000, 32'h0000_C000);
    random_items(60);

    repeat (3) begin
      settle(DRAIN_PAD);
      src_gaps  = $urandom_range(0, 3) != 0;
      sink_gaps = $urandom_range(0, 3) != 0;
      configure(nngs_pkg::bnd_mode_e'($urandom_range(0, 1)), $urandom, $urandom,
                $urandom_range(32'h2000, 32'h40000), $urandom_range(32'h2000, 32'h40000),
                9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)));
      random_items(55);
    end

    settle(DRAIN_PAD);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
